// ===== design/b64d_pkg.sv =====
// shared types, codes and character classification for the base64 stream decoder
`default_nettype none

package b64d_pkg;

  // data and result widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 16;
  localparam int unsigned GroupW = 24;
  localparam int unsigned SymW   = 6;
  localparam int unsigned MaxRes = 3;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_FULL = 2'd2,
    KIND_BAD  = 2'd3
  } kind_e;

  // character classes
  typedef enum logic [2:0] {
    CLS_SYM,
    CLS_PAD,
    CLS_SKIP,
    CLS_NUL,
    CLS_BAD
  } char_class_e;

  typedef struct packed {
    char_class_e     cls;
    logic [SymW-1:0] sym;
  } char_info_t;

  // per-string decoder state
  typedef struct packed {
    logic [GroupW-1:0] group_bits;
    logic [1:0]        group_pos;
    logic [CountW-1:0] bytes_written;
    logic              discarding;
  } str_state_t;

  // one result entry
  typedef struct packed {
    logic [CharW-1:0]  out_byte;
    kind_e             kind;
    logic [CountW-1:0] count;
  } result_t;

  // all results caused by one character
  typedef struct packed {
    result_t [MaxRes-1:0] res;
    logic    [1:0]        cnt;
  } burst_t;

  // map a character to its symbol value and class
  function automatic char_info_t classify(input logic [CharW-1:0] ch);
    char_info_t info;
    info.cls = CLS_BAD;
    info.sym = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      info.cls = CLS_SYM;
      info.sym = SymW'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      info.cls = CLS_SYM;
      info.sym = SymW'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      info.cls = CLS_SYM;
      info.sym = SymW'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      info.cls = CLS_SYM;
      info.sym = SymW'(62);
    end else if (ch == 8'h2F) begin
      info.cls = CLS_SYM;
      info.sym = SymW'(63);
    end else if (ch == 8'h3D) begin
      info.cls = CLS_PAD;
    end else if (ch == 8'h0A || ch == 8'h0D) begin
      info.cls = CLS_SKIP;
    end else if (ch == 8'h00) begin
      info.cls = CLS_NUL;
    end
    return info;
  endfunction

endpackage

`default_nettype wire

// ===== design/b64d_step.sv =====
// next-state and result burst logic for one incoming character
`default_nettype none

module b64d_step (
  input  wire b64d_pkg::str_state_t        state_i,
  input  wire [b64d_pkg::CountW-1:0]       cap_i,
  input  wire [b64d_pkg::CharW-1:0]        char_i,
  output b64d_pkg::str_state_t             state_o,
  output b64d_pkg::burst_t                 burst_o
);

  b64d_pkg::char_info_t               info;
  logic [b64d_pkg::GroupW-1:0]        gb_new;
  logic [1:0]                         n_bytes;
  logic [1:0]                         m_bytes;
  logic [b64d_pkg::CountW:0]          room;
  logic                               cap_hit;
  logic                               term;
  b64d_pkg::kind_e                    term_kind;

  assign info = b64d_pkg::classify(char_i);

  // merge the symbol into the group, first symbol at the top
  always_comb begin
    gb_new = state_i.group_bits;
    if (info.cls == b64d_pkg::CLS_SYM) begin
      gb_new = state_i.group_bits |
               (b64d_pkg::GroupW'(info.sym) << (5'd18 - 5'd6 * 5'(state_i.group_pos)));
    end
  end

  // bytes the character asks for, and how many still fit
  always_comb begin
    n_bytes = 2'd0;
    if (info.cls == b64d_pkg::CLS_PAD) begin
      case (state_i.group_pos)
        2'd2:    n_bytes = 2'd1;
        2'd3:    n_bytes = 2'd2;
        default: n_bytes = 2'd0;
      endcase
    end else if (info.cls == b64d_pkg::CLS_SYM && state_i.group_pos == 2'd3) begin
      n_bytes = 2'd3;
    end
    room    = {1'b0, cap_i} - {1'b0, state_i.bytes_written};
    cap_hit = state_i.bytes_written >= cap_i;
    if (cap_hit) begin
      m_bytes = 2'd0;
    end else if (room >= (b64d_pkg::CountW+1)'(n_bytes)) begin
      m_bytes = n_bytes;
    end else begin
      m_bytes = room[1:0];
    end
  end

  // terminal result and next string state
  always_comb begin
    state_o   = state_i;
    term      = 1'b0;
    term_kind = b64d_pkg::KIND_DONE;
    if (state_i.discarding) begin
      if (info.cls == b64d_pkg::CLS_NUL) begin
        state_o = '0;
      end
    end else begin
      unique case (info.cls)
        b64d_pkg::CLS_NUL: begin
          term      = 1'b1;
          term_kind = (state_i.group_pos == 2'd0) ? b64d_pkg::KIND_DONE : b64d_pkg::KIND_BAD;
          state_o   = '0;
        end
        b64d_pkg::CLS_BAD: begin
          term               = 1'b1;
          term_kind          = b64d_pkg::KIND_BAD;
          state_o.discarding = 1'b1;
        end
        b64d_pkg::CLS_PAD: begin
          term                  = 1'b1;
          term_kind             = (m_bytes < n_bytes) ? b64d_pkg::KIND_FULL
                                                      : b64d_pkg::KIND_DONE;
          state_o.bytes_written = state_i.bytes_written + b64d_pkg::CountW'(m_bytes);
          state_o.discarding    = 1'b1;
        end
        b64d_pkg::CLS_SYM: begin
          if (state_i.group_pos != 2'd3) begin
            state_o.group_bits = gb_new;
            state_o.group_pos  = state_i.group_pos + 2'd1;
          end else begin
            term                  = m_bytes < n_bytes;
            term_kind             = b64d_pkg::KIND_FULL;
            state_o.group_bits    = '0;
            state_o.group_pos     = 2'd0;
            state_o.bytes_written = state_i.bytes_written + b64d_pkg::CountW'(m_bytes);
            state_o.discarding    = m_bytes < n_bytes;
          end
        end
        default: ;
      endcase
    end
  end

  // build the burst: data bytes first, then the terminal result
  always_comb begin
    logic active;
    active  = !state_i.discarding;
    burst_o = '0;
    for (int i = 0; i < b64d_pkg::MaxRes; i++) begin
      if (active && 2'(i) < m_bytes) begin
        burst_o.res[i].out_byte = gb_new[b64d_pkg::GroupW-1-8*i -: 8];
        burst_o.res[i].kind     = b64d_pkg::KIND_DATA;
        burst_o.res[i].count    = state_i.bytes_written + b64d_pkg::CountW'(i) + 16'd1;
      end else if (active && term && 2'(i) == m_bytes) begin
        burst_o.res[i].out_byte = '0;
        burst_o.res[i].kind     = term_kind;
        burst_o.res[i].count    = state_i.bytes_written + b64d_pkg::CountW'(m_bytes);
      end
    end
    if (active) begin
      burst_o.cnt = m_bytes + 2'(term);
    end
  end

endmodule

`default_nettype wire

// ===== design/base64_stream_decoder_top.sv =====
// top level of the base64 stream decoder: state, result burst buffer and ports
//
// Takes one encoded character per cycle, unless a burst is still pending, and decodes it
// in the same cycle into a burst of zero to three results, held in a burst register that
// feeds the output one result per cycle while the sink is ready. A character that causes
// no result (a symbol inside a group, CR, LF or anything dropped while discarding) does
// not stall the input. A character that causes several results holds the output until
// the last of them leaves; the next character is taken in the cycle in which the last
// result of the previous burst leaves, so with a ready sink the input rate is one
// character per cycle except after full groups and '=', set by the single output port
// of the burst register. The capacity register is written through the cfg channel,
// which is always ready, and applies from the next character on.
`default_nettype none

module base64_stream_decoder_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration write channel: output_capacity
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [b64d_pkg::CountW-1:0]   cfg_data_i,
  // encoded characters
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [7:0]                    s_axis_tdata,   // [7:0] in_char
  // decoded results
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [23:0]                  m_axis_tdata,   // [7:0] out_byte, [23:8] decoded_count
  output logic [1:0]                   m_axis_tuser,   // [1:0] kind
  output logic                         m_axis_tlast    // last
);

  b64d_pkg::str_state_t              state_q, state_d;
  logic [b64d_pkg::CountW-1:0]       cap_q;
  b64d_pkg::burst_t                  burst_q, burst_d;
  logic                              bvalid_q;
  logic [1:0]                        idx_q;
  logic                              in_acc, out_acc, out_last;
  b64d_pkg::result_t                 cur;

  // per-character decode
  b64d_step u_step (
    .state_i (state_q),
    .cap_i   (cap_q),
    .char_i  (s_axis_tdata),
    .state_o (state_d),
    .burst_o (burst_d)
  );

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign out_last      = idx_q == (burst_q.cnt - 2'd1);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = !bvalid_q || (out_acc && out_last);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // output mux over the burst register
  assign cur           = burst_q.res[idx_q];
  assign m_axis_tvalid = bvalid_q;
  assign m_axis_tdata  = {cur.count, cur.out_byte};
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tlast  = out_last;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '1;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // burst control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= 1'b0;
      idx_q    <= 2'd0;
    end else if (in_acc && burst_d.cnt != 2'd0) begin
      bvalid_q <= 1'b1;
      idx_q    <= 2'd0;
    end else if (out_acc) begin
      if (out_last) begin
        bvalid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // burst payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= '0;
    end else if (in_acc && burst_d.cnt != 2'd0) begin
      burst_q <= burst_d;
    end
  end

  // a held burst always has at least one result and the index stays inside it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid_q |-> (burst_q.cnt != 2'd0 && idx_q < burst_q.cnt))
    else $error("burst register holds an empty burst or index overrun");

  // no new character while an earlier burst still has results beyond this cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!bvalid_q || (out_acc && out_last)))
    else $error("character taken while burst still pending");

  // a NUL seen while discarding starts a clean string
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && state_q.discarding && s_axis_tdata == 8'h00) |=>
      (state_q == '0))
    else $error("string state not cleared by NUL");

  // only the final result of a burst may be a terminal result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bvalid_q && !out_last) |-> (cur.kind == b64d_pkg::KIND_DATA))
    else $error("terminal result before end of burst");

endmodule

`default_nettype wire
